>>> rtl/qre_pkg.sv
// Package for the QC-LDPC row expander: sizes, command and register codes,
// state encoding and the structs shared by the walker, result FIFO and top.
// No dependencies.
package qre_pkg;

  // Sizing
  localparam int MAX_BASE_COLS = 32;
  localparam int MAX_LIFT      = 128;
  localparam int TABLE_DEPTH   = 512;
  localparam int RESULT_LIMIT  = 32;
  localparam int COL_LIMIT     = (MAX_BASE_COLS < RESULT_LIMIT) ? MAX_BASE_COLS : RESULT_LIMIT;

  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COL_W       = $clog2(COL_LIMIT + 1);
  localparam int Z_W         = $clog2(MAX_LIFT + 1);
  localparam int SHIFT_W     = 8;
  localparam int SHIFT_IDX_W = SHIFT_W - 1;
  localparam int SHIFT_RANGE = 1 << SHIFT_IDX_W;
  localparam int SUM_W       = SHIFT_IDX_W + 1;
  localparam int CMP_W       = (Z_W > SUM_W) ? Z_W : SUM_W;
  localparam int POS_W       = 12;
  localparam int CIDX_W      = 12;
  localparam int ORD_W       = 6;

  // Result FIFO
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Empty circulant marker stored in the base table
  localparam logic [SHIFT_W-1:0] SHIFT_EMPTY = '1;

  // Commands
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_EXPAND = 1'b1;

  typedef enum logic [2:0] {
    REG_QC_WIDTH   = 3'd0,
    REG_X_OFFSET   = 3'd1,
    REG_Y_OFFSET   = 3'd2,
    REG_SUB_WIDTH  = 3'd3,
    REG_SUB_HEIGHT = 3'd4,
    REG_LIFT_SIZE  = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Configuration as seen by the walker (width and z already clamped)
  typedef struct packed {
    logic [5:0]       qc_width;
    logic [4:0]       x_offset;
    logic [3:0]       y_offset;
    logic [COL_W-1:0] width;
    logic [4:0]       sub_height;
    logic [Z_W-1:0]   z;
  } cfg_t;

  typedef struct packed {
    logic               command;
    logic [8:0]         base_position;
    logic [SHIFT_W-1:0] shift_value;
    logic [3:0]         block_row;
    logic [6:0]         row_in_cell;
  } req_t;

  typedef struct packed {
    logic [CIDX_W-1:0] column_index;
    logic [ORD_W-1:0]  ordinal;
    logic              is_last;
    logic              empty_row;
    logic              row_error;
  } res_t;

endpackage

>>> rtl/qre_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port,
// read data registered. No dependencies.
module qre_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/qre_fifo.sv
// Small result FIFO between the row walker and the output stream.
// Depends on qre_pkg (res_t, FIFO sizes).
module qre_fifo
  import qre_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  res_t               push_data,
  output logic               head_valid,
  input  logic               head_ready,
  output res_t               head,
  output logic [FIFO_CW-1:0] count
);

  res_t               slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic               pop;

  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign pop        = head_valid && head_ready;

  // Storage; the walker never pushes into a full FIFO
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/qre_walker.sv
// Row walker: base table and residue table memories, clearing pass,
// load handling and the column pipeline that feeds the FIFO.
// Depends on qre_pkg and qre_ram.
module qre_walker
  import qre_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               lift_wr,
  input  logic               in_valid,
  output logic               in_ready,
  input  req_t               req,
  output logic               push,
  output res_t               push_data,
  input  logic [FIFO_CW-1:0] fifo_count
);

  state_t state;
  state_t state_next;

  // Control outputs of the FSM
  logic issue;
  logic fin_push;
  logic accept;
  logic expand_go;

  // Clearing pass and residue table sweep
  logic [ADDR_W-1:0]      clr_cnt;
  logic                   mod_busy;
  logic [SHIFT_IDX_W-1:0] msw_addr;
  logic [SHIFT_IDX_W-1:0] msw_res;
  logic [SHIFT_IDX_W-1:0] msw_res_next;

  // Base table ports
  logic               bwe;
  logic [ADDR_W-1:0]  bwaddr;
  logic [SHIFT_W-1:0] bwdata;
  logic [SHIFT_W-1:0] base_q;
  logic [SHIFT_IDX_W-1:0] mod_q;

  // Request checks
  logic [4:0]       row_sum;
  logic [POS_W-1:0] row_pos;
  logic [POS_W-1:0] start_pos;
  logic [POS_W-1:0] end_pos;
  logic             req_bad;
  logic             pos_bad;
  logic             row_err;
  logic             load_ok;

  // Walk registers
  logic [ADDR_W-1:0] rd_addr;
  logic [COL_W-1:0]  cols_left;
  logic [CIDX_W-1:0] cbase;
  logic [6:0]        ric_q;
  logic              err_q;

  // Pipeline stages
  logic              s1_valid;
  logic              s1_last;
  logic [CIDX_W-1:0] s1_cbase;
  logic              s2_valid;
  logic              s2_end;
  logic [CIDX_W-1:0] s2_cbase;

  // Stage 2 arithmetic
  logic [SUM_W-1:0]  sum;
  logic [CMP_W-1:0]  sum_w;
  logic [CMP_W-1:0]  z_w;
  logic [CMP_W-1:0]  resid;
  logic [CIDX_W-1:0] col_idx;

  // Held entry, emitted once the next one or the row end is known
  logic              pend_valid;
  logic [CIDX_W-1:0] pend_col;
  logic [ORD_W-1:0]  pend_ord;
  logic [ORD_W-1:0]  ord_cnt;

  assign accept    = in_valid && in_ready;
  assign expand_go = accept && (req.command == CMD_EXPAND);

  // Range checks on an expand request
  always_comb begin
    row_sum   = {1'b0, req.block_row} + {1'b0, cfg.y_offset};
    row_pos   = POS_W'(row_sum) * POS_W'(cfg.qc_width);
    start_pos = row_pos + POS_W'(cfg.x_offset);
    end_pos   = start_pos + POS_W'(cfg.width) - POS_W'(1);
    req_bad   = (cfg.z == '0) || ({1'b0, req.block_row} >= cfg.sub_height) ||
                (CMP_W'(req.row_in_cell) >= CMP_W'(cfg.z));
    pos_bad   = (cfg.width != '0) && (end_pos >= POS_W'(TABLE_DEPTH));
    row_err   = req_bad || pos_bad;
    load_ok   = (int'(req.base_position) < TABLE_DEPTH);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == ADDR_W'(TABLE_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (expand_go) begin
          state_next = (row_err || cfg.width == '0) ? ST_FINISH : ST_WALK;
        end
      end
      ST_WALK: begin
        if (issue && cols_left == COL_W'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (s2_end) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_push) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // FSM outputs; a read is issued only with room for every in-flight result
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    fin_push = 1'b0;
    unique case (state)
      ST_IDLE:   in_ready = !mod_busy;
      ST_WALK:   issue    = (fifo_count <= FIFO_CW'(FIFO_DEPTH - 3));
      ST_FINISH: fin_push = (fifo_count < FIFO_CW'(FIFO_DEPTH));
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Base table write: clearing pass or load command
  always_comb begin
    if (state == ST_CLEAR) begin
      bwe    = 1'b1;
      bwaddr = clr_cnt;
      bwdata = SHIFT_EMPTY;
    end else begin
      bwe    = accept && (req.command == CMD_LOAD) && load_ok;
      bwaddr = ADDR_W'(req.base_position);
      bwdata = req.shift_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == ST_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  qre_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (SHIFT_W)
  ) u_base_ram (
    .clk   (clk),
    .we    (bwe),
    .waddr (bwaddr),
    .wdata (bwdata),
    .raddr (rd_addr),
    .rdata (base_q)
  );

  // Residue table: entry s holds s mod z, rebuilt after reset and every z write
  assign msw_res_next = (CMP_W'(msw_res) + CMP_W'(1) == CMP_W'(cfg.z)) ? '0 :
                        msw_res + 1'b1;

  always_ff @(posedge clk) begin
    if (rst || lift_wr) begin
      mod_busy <= 1'b1;
      msw_addr <= '0;
      msw_res  <= '0;
    end else if (mod_busy) begin
      msw_addr <= msw_addr + 1'b1;
      msw_res  <= msw_res_next;
      if (msw_addr == SHIFT_IDX_W'(SHIFT_RANGE - 1)) begin
        mod_busy <= 1'b0;
      end
    end
  end

  qre_ram #(
    .DEPTH (SHIFT_RANGE),
    .WIDTH (SHIFT_IDX_W)
  ) u_mod_ram (
    .clk   (clk),
    .we    (mod_busy),
    .waddr (msw_addr),
    .wdata (msw_res),
    .raddr (base_q[SHIFT_IDX_W-1:0]),
    .rdata (mod_q)
  );

  // Walk setup on accept, address and column base advance on each issue
  always_ff @(posedge clk) begin
    if (expand_go) begin
      rd_addr   <= ADDR_W'(start_pos);
      cols_left <= cfg.width;
      cbase     <= '0;
      ric_q     <= req.row_in_cell;
      err_q     <= row_err;
    end else if (issue) begin
      rd_addr   <= rd_addr + 1'b1;
      cols_left <= cols_left - 1'b1;
      cbase     <= cbase + CIDX_W'(cfg.z);
    end
  end

  // Stage 1: table data back; stage 2: residue back
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s2_end   <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid && !base_q[SHIFT_W-1];
      s2_end   <= s1_valid && s1_last;
    end
  end

  always_ff @(posedge clk) begin
    s1_last  <= (cols_left == COL_W'(1));
    s1_cbase <= cbase;
    s2_cbase <= s1_cbase;
  end

  // (residue + row_in_cell) mod z with both terms below z
  always_comb begin
    sum     = {1'b0, mod_q} + SUM_W'(ric_q);
    sum_w   = CMP_W'(sum);
    z_w     = CMP_W'(cfg.z);
    resid   = (sum_w >= z_w) ? sum_w - z_w : sum_w;
    col_idx = s2_cbase + CIDX_W'(resid);
  end

  // Held entry and ordinal count
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (expand_go || fin_push) begin
      pend_valid <= 1'b0;
    end else if (s2_valid) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (expand_go) begin
      ord_cnt <= '0;
    end else if (s2_valid) begin
      ord_cnt  <= ord_cnt + 1'b1;
      pend_col <= col_idx;
      pend_ord <= ord_cnt + 1'b1;
    end
  end

  // Results into the FIFO
  always_comb begin
    push                   = (s2_valid && pend_valid) || fin_push;
    push_data.column_index = pend_col;
    push_data.ordinal      = pend_ord;
    push_data.is_last      = fin_push;
    push_data.empty_row    = 1'b0;
    push_data.row_error    = 1'b0;
    if (fin_push && !pend_valid) begin
      push_data.column_index = '0;
      push_data.ordinal      = '0;
      push_data.empty_row    = 1'b1;
      push_data.row_error    = err_q;
    end
  end

endmodule

>>> rtl/qc_ldpc_row_expander.sv
// QC-LDPC row expander: top level with configuration registers, row walker
// and result FIFO. Depends on qre_pkg, qre_walker, qre_fifo.
//
// Loads a quasi-cyclic base matrix of circulant shifts (negative = empty
// block) one entry per transfer, and expands one parity-check row per expand
// transfer into the column indices of its nonzero entries, in column order,
// numbered from 1, tlast on the final one. A row with no entries gives one
// result flagged empty; an out-of-range request or table position gives one
// result flagged empty and error. After reset the block clears the 512-entry
// base table and builds its 128-entry residue table, holding s_axis_tready low
// while it does so; a write of lift_size rebuilds the residue table, again
// holding s_axis_tready low. A load is written into the base table as it is
// accepted. An expand reads one base column per cycle from the table memory,
// and the result FIFO (8 entries) lets the next transfer be taken while
// earlier results drain; a stalled output pauses the column reads.
module qc_ldpc_row_expander
  import qre_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // base_position, shift_value, block_row, row_in_cell
  input  logic        s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // column_index, ordinal
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser,   // empty_row, row_error
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  logic [5:0] qc_width;
  logic [4:0] x_offset;
  logic [3:0] y_offset;
  logic [5:0] sub_width;
  logic [4:0] sub_height;
  logic [7:0] lift_size;

  cfg_t               cfg;
  req_t               req;
  res_t               push_data;
  res_t               head;
  logic               push;
  logic               lift_wr;
  logic [FIFO_CW-1:0] fifo_count;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      qc_width   <= 6'd24;
      x_offset   <= 5'd0;
      y_offset   <= 4'd0;
      sub_width  <= 6'd24;
      sub_height <= 5'd12;
      lift_size  <= 8'd27;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_QC_WIDTH:   qc_width   <= cfg_wdata[5:0];
        REG_X_OFFSET:   x_offset   <= cfg_wdata[4:0];
        REG_Y_OFFSET:   y_offset   <= cfg_wdata[3:0];
        REG_SUB_WIDTH:  sub_width  <= cfg_wdata[5:0];
        REG_SUB_HEIGHT: sub_height <= cfg_wdata[4:0];
        REG_LIFT_SIZE:  lift_size  <= cfg_wdata;
        default: begin
          qc_width <= qc_width;
        end
      endcase
    end
  end

  assign lift_wr = cfg_we && (reg_idx_t'(cfg_index) == REG_LIFT_SIZE);

  // Clamped views of the registers
  always_comb begin
    cfg.qc_width   = qc_width;
    cfg.x_offset   = x_offset;
    cfg.y_offset   = y_offset;
    cfg.sub_height = sub_height;
    cfg.width      = (int'(sub_width) > COL_LIMIT) ? COL_W'(COL_LIMIT) : COL_W'(sub_width);
    cfg.z          = (int'(lift_size) > MAX_LIFT) ? Z_W'(MAX_LIFT) : Z_W'(lift_size);
  end

  // Input unpacking
  always_comb begin
    req.command       = s_axis_tuser;
    req.base_position = s_axis_tdata[8:0];
    req.shift_value   = s_axis_tdata[16:9];
    req.block_row     = s_axis_tdata[20:17];
    req.row_in_cell   = s_axis_tdata[27:21];
  end

  qre_walker u_walker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .lift_wr    (lift_wr),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .req        (req),
    .push       (push),
    .push_data  (push_data),
    .fifo_count (fifo_count)
  );

  qre_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .head_valid (m_axis_tvalid),
    .head_ready (m_axis_tready),
    .head       (head),
    .count      (fifo_count)
  );

  // Output packing
  assign m_axis_tdata = {6'd0, head.ordinal, head.column_index};
  assign m_axis_tlast = head.is_last;
  assign m_axis_tuser = {head.row_error, head.empty_row};

endmodule

>>> rtl/qre_checker.sv
// Port-level checks for the QC-LDPC row expander, bound to the top level.
// Depends only on the top level's ports.
module qre_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [1:0]  m_axis_tuser
);

  // Clearing pass follows reset: no transfer is taken right after it
  a_clear_after_rst: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("input ready during clearing pass");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
                                        $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // An empty result ends its row and carries no entry
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata[17:0] == 18'd0))
    else $error("empty result not final or not zero");

  // Errors are always reported as empty rows
  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("error result not flagged empty");

  // Entries are numbered from one
  a_ordinal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[17:12] != 6'd0))
    else $error("entry with zero ordinal");

endmodule

bind qc_ldpc_row_expander qre_checker u_qre_checker (.*);
